[design/lcfr_pkg.sv]
// Package for the length-prefixed CRC-32 frame receiver.
// Holds the status codes, reset constants and the byte-wide CRC-32 update.
// Used by length_crc32_frame_receiver and lcfr_checker.
package lcfr_pkg;

    // Result status codes carried in tuser.
    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_BAD  = 2'd2,
        ST_LONG = 2'd3
    } t_status;

    // Receiver phase.
    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } t_phase;

    localparam logic [31:0] CRC_POLY         = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd1048576;
    localparam logic [2:0]  HDR_LAST_POS     = 3'd7;

    // Reflected CRC-32 update over one byte, one shift per bit.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[design/length_crc32_frame_receiver.sv]
// Top level of the length-prefixed frame receiver with CRC-32 body check.
// Depends on lcfr_pkg for status codes, constants and the CRC update.
//
// Channel   | Direction | Payload
// s_axis    | in        | tdata[7:0] = in_byte
// m_axis    | out       | tdata[7:0] = out_byte, tuser[0] = byte_valid,
//           |           | tuser[2:1] = status, tlast = last
// cfg       | in        | data[31:0] = max_length
//
// The CRC update and counters work in the cycle of acceptance and the
// result lands in the single output register. Sustained rate is one byte
// per cycle while results are taken, set by that output register.
// Reset is synchronous and active low; it clears the phase and counters,
// presets the CRC and sets max_length to 1048576. A stalled result holds;
// input keeps flowing whenever the output register is empty or being taken.
module length_crc32_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  o_m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic        o_m_axis_tlast,   // last
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data        // [31:0] max_length
);
    import lcfr_pkg::*;

    logic [31:0] r_max_length;
    t_phase      r_phase,     n_phase;
    logic [2:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [31:0] r_body_len,  n_body_len;
    logic [31:0] r_exp_crc,   n_exp_crc;
    logic [31:0] r_crc,       n_crc;
    logic [31:0] r_remaining, n_remaining;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_out_bv,    n_out_bv;
    logic        r_out_last,  n_out_last;
    t_status     r_out_st,    n_out_st;

    logic        in_accept;
    logic        out_accept;
    logic        res_new;
    logic [31:0] crc_next;
    logic [4:0]  lane_sh;

    // The configuration register is always ready to be written.
    assign o_cfg_ready = 1'b1;

    // Input is taken when the output register is free or being drained.
    assign out_accept      = r_out_valid && i_m_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign crc_next = crc_feed(r_crc, i_s_axis_tdata);
    assign lane_sh  = {r_hdr_cnt[1:0], 3'b000};

    // Frame state and result for one accepted byte.
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_body_len  = r_body_len;
        n_exp_crc   = r_exp_crc;
        n_crc       = r_crc;
        n_remaining = r_remaining;
        res_new     = 1'b0;
        n_out_byte  = r_out_byte;
        n_out_bv    = r_out_bv;
        n_out_last  = r_out_last;
        n_out_st    = r_out_st;
        if (in_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    // Length bytes first, then CRC bytes, little-endian.
                    if (!r_hdr_cnt[2]) begin
                        n_body_len[lane_sh +: 8] = i_s_axis_tdata;
                    end else begin
                        n_exp_crc[lane_sh +: 8] = i_s_axis_tdata;
                    end
                    if (r_hdr_cnt != HDR_LAST_POS) begin
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end else begin
                        n_hdr_cnt = 3'd0;
                        if (n_body_len > r_max_length) begin
                            res_new    = 1'b1;
                            n_out_byte = 8'd0;
                            n_out_bv   = 1'b0;
                            n_out_last = 1'b1;
                            n_out_st   = ST_LONG;
                        end else if (n_body_len == 32'd0) begin
                            // Empty body: the CRC of no bytes is zero.
                            res_new    = 1'b1;
                            n_out_byte = 8'd0;
                            n_out_bv   = 1'b0;
                            n_out_last = 1'b1;
                            n_out_st   = (n_exp_crc == 32'd0) ? ST_OK : ST_BAD;
                        end else begin
                            n_phase     = PH_BODY;
                            n_remaining = n_body_len;
                            n_crc       = CRC_INIT;
                        end
                    end
                end
                PH_BODY: begin
                    n_crc       = crc_next;
                    n_remaining = r_remaining - 32'd1;
                    res_new     = 1'b1;
                    n_out_byte  = i_s_axis_tdata;
                    n_out_bv    = 1'b1;
                    if (r_remaining == 32'd1) begin
                        n_phase    = PH_HEADER;
                        n_hdr_cnt  = 3'd0;
                        n_out_last = 1'b1;
                        n_out_st   = ((crc_next ^ CRC_INIT) == r_exp_crc) ? ST_OK : ST_BAD;
                    end else begin
                        n_out_last = 1'b0;
                        n_out_st   = ST_BUSY;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // Output register valid: set by a new result, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (res_new) begin
            n_out_valid = 1'b1;
        end else if (out_accept) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
            r_phase      <= PH_HEADER;
            r_hdr_cnt    <= 3'd0;
            r_body_len   <= 32'd0;
            r_exp_crc    <= 32'd0;
            r_crc        <= CRC_INIT;
            r_remaining  <= 32'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_length <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_body_len  <= n_body_len;
            r_exp_crc   <= n_exp_crc;
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded only with a new result.
    always_ff @(posedge i_clk) begin
        if (res_new) begin
            r_out_byte <= n_out_byte;
            r_out_bv   <= n_out_bv;
            r_out_last <= n_out_last;
            r_out_st   <= n_out_st;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = {r_out_st, r_out_bv};
    assign o_m_axis_tlast  = r_out_last;

endmodule

[design/lcfr_checker.sv]
// Port-level checker for the frame receiver, bound to the top level.
// Depends on lcfr_pkg for the status codes.
module lcfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import lcfr_pkg::*;

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // A result without a body byte carries a zero byte and ends a frame.
    a_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata == 8'd0 && o_m_axis_tlast &&
            o_m_axis_tuser[2:1] != ST_BUSY)
        else $error("empty result malformed");

    // In-progress status exactly on body bytes that do not end the frame.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tuser[2:1] == ST_BUSY) == !o_m_axis_tlast) &&
            !(o_m_axis_tuser[0] && o_m_axis_tuser[2:1] == ST_LONG))
        else $error("status and last disagree");

    // A fresh result follows an accepted input request.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && $past(i_rst_n) &&
        !($past(o_m_axis_tvalid) && !$past(i_m_axis_tready)) |->
            $past(i_s_axis_tvalid && o_s_axis_tready))
        else $error("result without input request");

endmodule

bind length_crc32_frame_receiver lcfr_checker u_lcfr_checker (.*);

[verif/length_crc32_frame_receiver_tb.sv]
// Self-checking testbench for the length-prefixed CRC-32 frame receiver.
// Predicts every result from its own copy of the receiver state and compares in order.
// Depends on lcfr_pkg and length_crc32_frame_receiver from the design folder.
module length_crc32_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcfr_pkg::*;

    // One result as it appears on the master side.
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
        t_status    status;
    } t_frame_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'd0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;     // [7:0] out_byte
    logic [2:0]  o_m_axis_tuser;     // [0] byte_valid, [2:1] status
    logic        o_m_axis_tlast;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data      = 32'd0;

    // Predicted receiver state and the limit register copy.
    t_phase      rx_phase;
    logic [2:0]  hdr_pos;
    logic [31:0] body_len;
    logic [31:0] hdr_crc;
    logic [31:0] body_crc;
    logic [31:0] bytes_left;
    logic [31:0] max_len;

    t_frame_result pending_results[$];

    int err_count    = 0;
    int results_seen = 0;
    int frames_ok    = 0;
    int frames_bad   = 0;
    int frames_long  = 0;
    int cfg_writes   = 0;
    int random_bytes = 0;
    int burst_left   = 0;
    int hold_cycles  = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;

    length_crc32_frame_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Reflected CRC-32 over one byte, folding in one data bit per shift.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic reset_receiver_model();
        rx_phase   = PH_HEADER;
        hdr_pos    = 3'd0;
        body_len   = 32'd0;
        hdr_crc    = 32'd0;
        body_crc   = CRC_INIT;
        bytes_left = 32'd0;
        max_len    = MAX_LENGTH_RESET;
    endtask

    task automatic push_result(input logic [7:0] d, input logic v, input logic l,
                               input t_status s);
        t_frame_result r;
        r.data       = d;
        r.byte_valid = v;
        r.last       = l;
        r.status     = s;
        pending_results.insert(pending_results.size(), r);
    endtask

    // Work out what one accepted stream byte produces.
    task automatic predict_byte(input logic [7:0] b);
        if (rx_phase == PH_HEADER) begin
            if (hdr_pos < 3'd4) begin
                body_len[{hdr_pos[1:0], 3'b000} +: 8] = b;
            end else begin
                hdr_crc[{hdr_pos[1:0], 3'b000} +: 8] = b;
            end
            if (hdr_pos != HDR_LAST_POS) begin
                hdr_pos = hdr_pos + 3'd1;
            end else begin
                hdr_pos = 3'd0;
                if (body_len > max_len) begin
                    push_result(8'd0, 1'b0, 1'b1, ST_LONG);
                end else if (body_len == 32'd0) begin
                    push_result(8'd0, 1'b0, 1'b1, (hdr_crc == 32'd0) ? ST_OK : ST_BAD);
                end else begin
                    rx_phase   = PH_BODY;
                    bytes_left = body_len;
                    body_crc   = CRC_INIT;
                end
            end
        end else begin
            body_crc   = crc32_byte(body_crc, b);
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 32'd0) begin
                rx_phase = PH_HEADER;
                hdr_pos  = 3'd0;
                push_result(b, 1'b1, 1'b1, ((~body_crc) == hdr_crc) ? ST_OK : ST_BAD);
            end else begin
                push_result(b, 1'b1, 1'b0, ST_BUSY);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("[%0t] mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 $realtime, results_seen, what, got, want);
    endtask

    task automatic check_result();
        t_frame_result want;
        t_status       got_status;
        got_status = t_status'(o_m_axis_tuser[2:1]);
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, tdata", 32'(o_m_axis_tdata), 32'd0);
        end else begin
            want = pending_results.pop_front();
            if (o_m_axis_tdata !== want.data) begin
                report_mismatch("out_byte", 32'(o_m_axis_tdata), 32'(want.data));
            end
            if (o_m_axis_tuser[0] !== want.byte_valid) begin
                report_mismatch("byte_valid", 32'(o_m_axis_tuser[0]), 32'(want.byte_valid));
            end
            if (o_m_axis_tlast !== want.last) begin
                report_mismatch("last", 32'(o_m_axis_tlast), 32'(want.last));
            end
            if (got_status !== want.status) begin
                report_mismatch("status", 32'(got_status), 32'(want.status));
            end
            if (want.last) begin
                case (want.status)
                    ST_OK:   frames_ok++;
                    ST_BAD:  frames_bad++;
                    ST_LONG: frames_long++;
                    default: ;
                endcase
            end
        end
        results_seen++;
    endtask

    // Monitor: check results, track limit writes and predict from accepted bytes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_receiver_model();
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_result();
            end
            if (i_cfg_valid && o_cfg_ready) begin
                max_len = i_cfg_data;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_byte(i_s_axis_tdata);
            end
        end
    end

    // Result side: a long hold-off when asked, otherwise a changing stall pattern.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left = rx_mode_left - 1;
            case (rx_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                default: i_m_axis_tready <= rx_mode_left[0];
            endcase
        end
    end

    // Offer one byte and wait for its request to be taken; gaps fall between bursts.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_word_le(input logic [31:0] w);
        logic [31:0] rest;
        rest = w;
        for (int i = 0; i < 4; i++) begin
            send_byte(rest[7:0]);
            rest = rest >> 8;
        end
    endtask

    // Send a header and, when the length fits the limit, a random body.
    task automatic send_frame(input logic [31:0] len, input bit crc_good);
        logic [7:0]  body[$];
        logic [31:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        if (len != 32'd0 && len <= max_len) begin
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(0, 255));
                body.insert(body.size(), b);
                crc = crc32_byte(crc, b);
            end
        end
        crc = ~crc;
        if (!crc_good) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        send_word_le(len);
        send_word_le(crc);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
    endtask

    // Stop offering, wait for every expected result, then let the pipeline settle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Headers against the reset limit, and empty bodies.
    task automatic test_reset_limit();
        send_frame(32'hFFFF_FFFF, 1'b1);
        send_frame(MAX_LENGTH_RESET + 32'd1, 1'b1);
        send_word_le(32'd0);
        send_word_le(32'd0);
        send_word_le(32'd0);
        send_word_le(32'hFFFF_FFFF);
        drain();
    endtask

    // The standard check string with its good and a wrong CRC, plus short bodies.
    task automatic test_known_crc();
        for (int k = 0; k < 2; k++) begin
            send_word_le(32'd9);
            send_word_le((k == 0) ? 32'hCBF4_3926 : 32'hCBF4_3927);
            for (int i = 0; i < 9; i++) begin
                send_byte(8'h31 + 8'(i));
            end
        end
        send_frame(32'd1, 1'b1);
        send_frame(32'd2, 1'b0);
        drain();
    endtask

    // Lengths right at and just past the limits 0 and 5, then the full range.
    task automatic test_limit_edges();
        write_max_length(32'd0);
        drain();
        send_frame(32'd0, 1'b1);
        send_frame(32'd1, 1'b1);
        drain();
        write_max_length(32'd5);
        drain();
        send_frame(32'd5, 1'b1);
        send_frame(32'd6, 1'b1);
        drain();
        write_max_length(32'hFFFF_FFFF);
        drain();
        send_frame(32'd3, 1'b1);
        send_frame(32'd0, 1'b0);
        drain();
    endtask

    // The result side holds off for a long time so the block stalls its input.
    task automatic test_backpressure();
        hold_cycles = 300;
        send_frame(32'd40, 1'b1);
        send_frame(32'd0, 1'b1);
        drain();
    endtask

    // Random frames under changing limits, with some too-long and noise headers.
    task automatic test_random_frames();
        int          frames_left;
        int          pick;
        logic [31:0] len;
        logic [31:0] lim;
        frames_left = 0;
        while (random_bytes < 600) begin
            if (frames_left == 0) begin
                drain();
                case ($urandom_range(0, 5))
                    0:       lim = 32'd0;
                    1:       lim = 32'd1;
                    2:       lim = 32'd16;
                    3:       lim = 32'd64;
                    4:       lim = $urandom_range(2, 200);
                    default: lim = 32'hFFFF_FFFF;
                endcase
                write_max_length(lim);
                drain();
                frames_left = 30;
            end
            frames_left--;
            pick = $urandom_range(0, 9);
            if (pick == 0 && max_len < 32'd1024) begin
                // Noise header: arbitrary length and CRC bytes.
                len = $urandom;
                send_frame(len, 1'($urandom_range(0, 1)));
            end else if (pick == 1 && max_len != 32'hFFFF_FFFF) begin
                len = (max_len > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF
                                                : max_len + 32'd1 + $urandom_range(0, 5);
                send_frame(len, 1'b1);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 48)
                                                  : $urandom_range(0, 12);
                send_frame(len, $urandom_range(0, 3) != 0);
            end
            random_bytes += 8;
            if (len <= max_len) begin
                random_bytes += int'(len);
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_max_length(MAX_LENGTH_RESET);
        drain();
        test_reset_limit();
        test_known_crc();
        test_limit_edges();
        test_backpressure();
        test_random_frames();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never seen, count", 32'd0, 32'(pending_results.size()));
        end
        $display("Checked %0d results: %0d frames ok, %0d CRC mismatches, %0d too long.",
                 results_seen, frames_ok, frames_bad, frames_long);
        $display("%0d limit writes, from zero to the full 32-bit range, under random stalls.",
                 cfg_writes);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/lcfr_pkg.sv
design/length_crc32_frame_receiver.sv
design/lcfr_checker.sv
verif/length_crc32_frame_receiver_tb.sv
